// File: hw/rtl/pcsp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the PNG chunk stream parser.
// No dependencies; compile first.
package pcsp_pkg;

   // Parser phases; the unused codes behave like a stopped parser.
   typedef enum logic [3:0] {
      PH_SIG    = 4'd0,
      PH_LEN    = 4'd1,
      PH_TYPE   = 4'd2,
      PH_FIELDS = 4'd3,
      PH_SKIP   = 4'd4,
      PH_ENDCRC = 4'd5,
      PH_DONE   = 4'd6,
      PH_ERROR  = 4'd7
   } phase_type;

   typedef logic [2:0] event_code_type;
   typedef logic [2:0] chunk_kind_type;

   localparam event_code_type EV_SIG_OK = 3'd0;
   localparam event_code_type EV_SIG_BAD = 3'd1;
   localparam event_code_type EV_CHUNK_HEADER = 3'd2;
   localparam event_code_type EV_IMAGE_HEADER = 3'd3;
   localparam event_code_type EV_END = 3'd4;

   localparam chunk_kind_type KIND_IHDR = 3'd0;
   localparam chunk_kind_type KIND_PLTE = 3'd1;
   localparam chunk_kind_type KIND_IDAT = 3'd2;
   localparam chunk_kind_type KIND_IEND = 3'd3;
   localparam chunk_kind_type KIND_OTHER = 3'd4;

   localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
   localparam logic [31:0] TYPE_PLTE = 32'h504C_5445;
   localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
   localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

   localparam int unsigned SIG_BYTES = 8;
   localparam int unsigned WORD_BYTES = 4;
   localparam int unsigned IHDR_BYTES = 13;
   localparam int unsigned CRC_BYTES = 4;

   // PNG file signature, one byte per position.
   function automatic logic [7:0] sig_byte(input logic [2:0] idx);
      logic [7:0] val;
      case (idx)
         3'd0: val = 8'd137;
         3'd1: val = 8'd80;
         3'd2: val = 8'd78;
         3'd3: val = 8'd71;
         3'd4: val = 8'd13;
         3'd5: val = 8'd10;
         3'd6: val = 8'd26;
         3'd7: val = 8'd10;
         default: val = 8'd0;
      endcase
      return val;
   endfunction

   function automatic chunk_kind_type kind_of(input logic [31:0] code);
      chunk_kind_type kind;
      if (code == TYPE_IHDR) begin
         kind = KIND_IHDR;
      end else if (code == TYPE_PLTE) begin
         kind = KIND_PLTE;
      end else if (code == TYPE_IDAT) begin
         kind = KIND_IDAT;
      end else if (code == TYPE_IEND) begin
         kind = KIND_IEND;
      end else begin
         kind = KIND_OTHER;
      end
      return kind;
   endfunction

endpackage

// File: hw/rtl/pcsp_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the PNG chunk stream parser.
// Depends on pcsp_pkg for the event and kind code types.

interface pcsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface pcsp_rsp_if;
   logic                      valid;
   logic                      ready;
   pcsp_pkg::event_code_type  event_code;
   pcsp_pkg::chunk_kind_type  chunk_kind;
   logic [31:0]               chunk_length;
   logic [31:0]               chunk_type_code;
   logic [30:0]               palette_entries;
   logic [31:0]               image_width;
   logic [31:0]               image_height;
   logic [7:0]                pixel_depth;
   logic [7:0]                colour_mode;
   logic [7:0]                compression_method;
   logic [7:0]                filter_method;
   logic [7:0]                interlace_method;

   modport source (
      output valid, output event_code, output chunk_kind, output chunk_length,
      output chunk_type_code, output palette_entries, output image_width,
      output image_height, output pixel_depth, output colour_mode,
      output compression_method, output filter_method, output interlace_method,
      input ready
   );
   modport sink (
      input valid, input event_code, input chunk_kind, input chunk_length,
      input chunk_type_code, input palette_entries, input image_width,
      input image_height, input pixel_depth, input colour_mode,
      input compression_method, input filter_method, input interlace_method,
      output ready
   );
endinterface

// File: hw/rtl/png_chunk_stream_parser.sv
`timescale 1ns / 1ps
// PNG chunk stream parser, top level.
// Depends on pcsp_pkg and the channel interfaces in pcsp_if.sv.
//
// Usage:
//   req  carries the PNG file one byte per request (data_byte).
//   rsp  carries parser events: signature ok or bad, chunk header (kind,
//        length, type, palette count for PLTE), the IHDR fields, and end.
//   Every byte passes through one level of logic against the parser state
//   and, if it completes an event, lands in the output register. An event
//   is therefore visible on rsp in the cycle after the request that caused it.
//   Throughput is one byte per cycle; it is limited only by the single
//   output register, which req may refill in the cycle it is drained.
//   The palette count (length / 3) is built a byte at a time as the length
//   arrives, by a radix-256 long division with a two-bit remainder.
//   A stalled receiver holds the output register; req.ready then drops
//   until the pending event is taken, so no event is lost or duplicated.
//   Bytes that cause no event are still only accepted while the output
//   register is free or being drained.
//   Synchronous reset returns to the signature phase with an empty output.
//   After the end event or a bad signature all further bytes are accepted
//   and dropped.

module png_chunk_stream_parser (
   input  logic          clock,
   input  logic          reset,
   pcsp_req_if.sink      req,
   pcsp_rsp_if.source    rsp
);

   // Parser state
   pcsp_pkg::phase_type phase_ff, phase_in;
   logic [3:0]   pos_ff, pos_in;
   logic         sig_match_ff, sig_match_in;
   logic [31:0]  len_ff, len_in;
   logic [31:0]  type_ff, type_in;
   logic [32:0]  skip_ff, skip_in;
   logic [103:0] hdr_ff, hdr_in;
   logic [30:0]  quot_ff, quot_in;
   logic [1:0]   rem_ff, rem_in;

   // Output register
   logic         rsp_valid_ff;
   pcsp_pkg::event_code_type ev_ff, ev_in;
   pcsp_pkg::chunk_kind_type kind_ff, kind_in;
   logic [31:0]  olen_ff, olen_in;
   logic [31:0]  otype_ff, otype_in;
   logic [30:0]  opal_ff, opal_in;
   logic [103:0] ohdr_ff, ohdr_in;
   logic         emit;

   logic         accept;
   logic [7:0]   b;
   logic [3:0]   pos_inc;
   logic [31:0]  type_shift;
   logic [103:0] hdr_shift;
   pcsp_pkg::chunk_kind_type kind_now;
   logic [1:0]   rem_base;
   logic [9:0]   div_val;
   logic [19:0]  div_prod;
   logic [7:0]   div_digit;
   logic [9:0]   div_back;

   // Take a byte whenever the output register is free or being drained.
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept = req.valid && req.ready;
   assign b = req.data_byte;

   assign pos_inc = pos_ff + 4'd1;
   assign type_shift = {type_ff[23:0], b};
   assign hdr_shift = {hdr_ff[95:0], b};
   assign kind_now = pcsp_pkg::kind_of(type_shift);

   // One long-division digit by three: value below 768, so x*683 >> 11 is exact.
   assign rem_base = (pos_ff == 4'd0) ? 2'd0 : rem_ff;
   assign div_val = {rem_base, b};
   assign div_prod = {10'd0, div_val} * 20'd683;
   assign div_digit = div_prod[18:11];
   assign div_back = div_val - ({2'd0, div_digit} + {1'b0, div_digit, 1'b0});

   always_comb begin
      phase_in = phase_ff;
      pos_in = pos_ff;
      sig_match_in = sig_match_ff;
      len_in = len_ff;
      type_in = type_ff;
      skip_in = skip_ff;
      hdr_in = hdr_ff;
      quot_in = quot_ff;
      rem_in = rem_ff;
      emit = 1'b0;
      ev_in = pcsp_pkg::EV_SIG_OK;
      kind_in = pcsp_pkg::KIND_IHDR;
      olen_in = 32'd0;
      otype_in = 32'd0;
      opal_in = 31'd0;
      ohdr_in = 104'd0;

      unique case (phase_ff)
         pcsp_pkg::PH_SIG: begin
            sig_match_in = sig_match_ff && (b == pcsp_pkg::sig_byte(pos_ff[2:0]));
            pos_in = pos_inc;
            if (pos_inc == 4'(pcsp_pkg::SIG_BYTES)) begin
               pos_in = 4'd0;
               emit = 1'b1;
               ev_in = sig_match_in ? pcsp_pkg::EV_SIG_OK : pcsp_pkg::EV_SIG_BAD;
               phase_in = sig_match_in ? pcsp_pkg::PH_LEN : pcsp_pkg::PH_ERROR;
            end
         end
         pcsp_pkg::PH_LEN: begin
            len_in = {len_ff[23:0], b};
            quot_in = {quot_ff[22:0], div_digit};
            rem_in = div_back[1:0];
            pos_in = pos_inc;
            if (pos_inc == 4'(pcsp_pkg::WORD_BYTES)) begin
               pos_in = 4'd0;
               phase_in = pcsp_pkg::PH_TYPE;
            end
         end
         pcsp_pkg::PH_TYPE: begin
            type_in = type_shift;
            pos_in = pos_inc;
            if (pos_inc == 4'(pcsp_pkg::WORD_BYTES)) begin
               pos_in = 4'd0;
               emit = 1'b1;
               ev_in = pcsp_pkg::EV_CHUNK_HEADER;
               kind_in = kind_now;
               olen_in = len_ff;
               otype_in = type_shift;
               opal_in = (kind_now == pcsp_pkg::KIND_PLTE) ? quot_ff : 31'd0;
               if (kind_now == pcsp_pkg::KIND_IHDR) begin
                  phase_in = pcsp_pkg::PH_FIELDS;
               end else if (kind_now == pcsp_pkg::KIND_IEND) begin
                  phase_in = pcsp_pkg::PH_ENDCRC;
               end else begin
                  skip_in = {1'b0, len_ff} + 33'(pcsp_pkg::CRC_BYTES);
                  phase_in = pcsp_pkg::PH_SKIP;
               end
            end
         end
         pcsp_pkg::PH_FIELDS: begin
            hdr_in = hdr_shift;
            pos_in = pos_inc;
            if (pos_inc == 4'(pcsp_pkg::IHDR_BYTES)) begin
               pos_in = 4'd0;
               emit = 1'b1;
               ev_in = pcsp_pkg::EV_IMAGE_HEADER;
               kind_in = pcsp_pkg::KIND_IHDR;
               olen_in = len_ff;
               otype_in = type_ff;
               ohdr_in = hdr_shift;
               skip_in = 33'(pcsp_pkg::CRC_BYTES);
               phase_in = pcsp_pkg::PH_SKIP;
            end
         end
         pcsp_pkg::PH_SKIP: begin
            if (skip_ff != 33'd0) begin
               skip_in = skip_ff - 33'd1;
            end
            if (skip_in == 33'd0) begin
               len_in = 32'd0;
               type_in = 32'd0;
               phase_in = pcsp_pkg::PH_LEN;
            end
         end
         pcsp_pkg::PH_ENDCRC: begin
            pos_in = pos_inc;
            if (pos_inc == 4'(pcsp_pkg::CRC_BYTES)) begin
               pos_in = 4'd0;
               emit = 1'b1;
               ev_in = pcsp_pkg::EV_END;
               kind_in = pcsp_pkg::KIND_IEND;
               olen_in = len_ff;
               otype_in = type_ff;
               phase_in = pcsp_pkg::PH_DONE;
            end
         end
         default: begin
            // stopped: drop the byte
         end
      endcase
   end

   // Parser state advances only on an accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pcsp_pkg::PH_SIG;
         pos_ff <= 4'd0;
         sig_match_ff <= 1'b1;
         len_ff <= 32'd0;
         type_ff <= 32'd0;
         skip_ff <= 33'd0;
         hdr_ff <= 104'd0;
         quot_ff <= 31'd0;
         rem_ff <= 2'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         sig_match_ff <= sig_match_in;
         len_ff <= len_in;
         type_ff <= type_in;
         skip_ff <= skip_in;
         hdr_ff <= hdr_in;
         quot_ff <= quot_in;
         rem_ff <= rem_in;
      end
   end

   // Output register: load a new event, else drop the old one once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         ev_ff <= ev_in;
         kind_ff <= kind_in;
         olen_ff <= olen_in;
         otype_ff <= otype_in;
         opal_ff <= opal_in;
         ohdr_ff <= ohdr_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.event_code = ev_ff;
   assign rsp.chunk_kind = kind_ff;
   assign rsp.chunk_length = olen_ff;
   assign rsp.chunk_type_code = otype_ff;
   assign rsp.palette_entries = opal_ff;
   assign rsp.image_width = ohdr_ff[103:72];
   assign rsp.image_height = ohdr_ff[71:40];
   assign rsp.pixel_depth = ohdr_ff[39:32];
   assign rsp.colour_mode = ohdr_ff[31:24];
   assign rsp.compression_method = ohdr_ff[23:16];
   assign rsp.filter_method = ohdr_ff[15:8];
   assign rsp.interlace_method = ohdr_ff[7:0];

endmodule
